// File: rtl/sprite_clip_frame_timeline_macros.svh
// assertion macros shared by the sprite clip timeline rtl
`ifndef SPRITE_CLIP_FRAME_TIMELINE_MACROS_SVH
`define SPRITE_CLIP_FRAME_TIMELINE_MACROS_SVH

// checked while out of reset
`define SCFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SCFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/scft_pkg.sv
// package with sizes, types and helpers of the sprite clip timeline
package scft_pkg;

  localparam int MAX_FRAMES    = 64;
  localparam int DURATION_BITS = 16;

  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int STEP_W  = $clog2(2 * MAX_FRAMES);
  localparam int PER_W   = DURATION_BITS + STEP_W;
  localparam int DIVD_W  = 64;
  localparam int CNT_W   = $clog2(DIVD_W);
  localparam int FC_W    = 7;
  localparam int ADDR_W  = 4;

  typedef enum logic [1:0] {
    REG_CLIP_LEN = 2'd0,
    REG_LOOP     = 2'd1,
    REG_PINGPONG = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [FC_W-1:0] clip_len;
    logic            loop_en;
    logic            pingpong_en;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [PER_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [PER_W-1:0]  remainder;
  } div_rsp_t;

  // forward through the frames, then back through the middle ones
  function automatic logic [STEP_W-1:0] frame_of_step(input logic [STEP_W-1:0] s,
                                                      input logic [STEP_W-1:0] n);
    logic [STEP_W-1:0] back;
    back = (n << 1) - STEP_W'(2) - s;
    return (s < n) ? s : back;
  endfunction

endpackage

// File: rtl/scft_regs.sv
// apb configuration registers of the sprite clip timeline
module scft_regs
  import scft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_CLIP_LEN: cfg_q.clip_len    <= pwdata[FC_W-1:0];
        REG_LOOP:     cfg_q.loop_en     <= pwdata[0];
        REG_PINGPONG: cfg_q.pingpong_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CLIP_LEN: prdata = 32'(cfg_q.clip_len);
      REG_LOOP:     prdata = 32'(cfg_q.loop_en);
      REG_PINGPONG: prdata = 32'(cfg_q.pingpong_en);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/scft_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module scft_div
  import scft_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [PER_W-1:0]  rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [PER_W-1:0]  dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q;
  logic              done_q;
  logic [PER_W:0]    trial;
  logic [PER_W:0]    diff;
  logic              fits;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q <= '0;
        quo_q <= req_i.dividend;
        dvs_q <= req_i.divisor;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
        quo_q <= {quo_q[DIVD_W-2:0], fits};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/sprite_clip_frame_timeline.sv
// top level of the sprite clip timeline: sequencer, duration table, divider
// usage:
//   configuration goes through the apb port (clip length at 0x0, loop at 0x4,
//   ping-pong at 0x8), written only while busy is low and no query is pending.
//   a request is taken at a rising edge with start high and busy low.
//   cmd_i high writes frame_duration_i into slot frame_slot_i,
//   gives no result and leaves busy low.
//   cmd_i low is a query: busy stays high while the sequencer walks the
//   duration table once for the period, runs the serial divider for the
//   loop count when looping, walks the table again to find the step, and
//   runs the divider once more for the step position within the cycle.
//   with looping on busy also waits for the loop-count division; the single
//   table read port and the one-bit-per-cycle divider set how long busy
//   stays high.
//   an empty clip ends the query after the first table walk, without the divider.
//   the result sits on the result ports for one cycle with res_valid_o high,
//   in the cycle busy falls; the receiver cannot stall and must take it then.
//   reset clears the configuration and the sequencer; table contents stay
//   undefined until written, and there is no clearing pass.
module sprite_clip_frame_timeline
  import scft_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd_i,
  input  logic [FRAME_W-1:0]       frame_slot_i,
  input  logic [DURATION_BITS-1:0] frame_duration_i,
  input  logic [63:0]              query_time_i,
  output logic                     res_valid_o,
  output logic [FRAME_W-1:0]       shown_frame_o,
  output logic [63:0]              step_number_o,
  output logic                     done_res_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  `include "sprite_clip_frame_timeline_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_CHECK, ST_DIV1, ST_MUL, ST_SCAN, ST_MOD, ST_DIV2
  } state_e;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e                  state_q;
  logic [63:0]             t_q;
  logic [STEP_W-1:0]       nf_q;
  logic [STEP_W-1:0]       steps_q;
  logic [STEP_W-1:0]       s_q;
  logic [STEP_W-1:0]       rd_step_q;
  logic                    rd_vld_q;
  logic [PER_W-1:0]        acc_q;
  logic [PER_W-1:0]        period_q;
  logic [63:0]             cycle_q;
  logic [PER_W-1:0]        rem_q;
  logic [63:0]             base_q;
  logic [63:0]             ord_q;
  logic                    done_q;
  logic                    res_valid_q;
  logic [FRAME_W-1:0]      shown_q;
  logic [63:0]             step_q;
  logic                    res_done_q;

  logic [DURATION_BITS-1:0] mem [MAX_FRAMES];
  logic [DURATION_BITS-1:0] rdata_q;

  logic [STEP_W-1:0]        nf_c;
  logic [STEP_W-1:0]        steps_c;
  logic [STEP_W-1:0]        raddr_step;
  logic [STEP_W-1:0]        out_step;
  logic [PER_W:0]           scan_sum;
  logic [64+STEP_W-1:0]     prod;
  logic                     accept;
  logic                     issue;
  logic                     t_over;

  scft_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scft_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign nf_c = (cfg.clip_len > FC_W'(MAX_FRAMES)) ? STEP_W'(MAX_FRAMES)
                                                  : STEP_W'(cfg.clip_len);

  always_comb begin
    if (nf_c == '0) begin
      steps_c = '0;
    end else if (nf_c == STEP_W'(1) || !cfg.pingpong_en) begin
      steps_c = nf_c;
    end else begin
      steps_c = (nf_c << 1) - STEP_W'(2);
    end
  end

  assign raddr_step = frame_of_step(s_q, nf_q);
  assign out_step   = frame_of_step(div_rsp.remainder[STEP_W-1:0], nf_q);
  assign issue      = (s_q < steps_q);
  assign scan_sum   = {1'b0, acc_q} + (PER_W + 1)'(rdata_q);
  assign prod       = (64 + STEP_W)'(cycle_q) * (64 + STEP_W)'(steps_q);
  assign t_over     = (t_q >= 64'(period_q));

  always_comb begin
    div_req.start    = ((state_q == ST_CHECK) && cfg.loop_en && steps_q != '0
                        && period_q != '0) || (state_q == ST_MOD);
    div_req.dividend = (state_q == ST_MOD) ? ord_q : t_q;
    div_req.divisor  = (state_q == ST_MOD) ? PER_W'(steps_q) : period_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i) begin
      mem[frame_slot_i] <= frame_duration_i;
    end
    rdata_q <= mem[raddr_step[FRAME_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      s_q         <= '0;
      steps_q     <= '0;
      nf_q        <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && !cmd_i) begin
            t_q      <= query_time_i;
            nf_q     <= nf_c;
            steps_q  <= steps_c;
            s_q      <= '0;
            acc_q    <= '0;
            rd_vld_q <= 1'b0;
            state_q  <= ST_SUM;
          end
        end
        ST_SUM: begin
          rd_vld_q  <= issue;
          rd_step_q <= s_q;
          if (issue) begin
            s_q <= s_q + STEP_W'(1);
          end
          if (rd_vld_q) begin
            acc_q <= acc_q + PER_W'(rdata_q);
          end
          if (!issue && !rd_vld_q) begin
            period_q <= acc_q;
            state_q  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          done_q <= !cfg.loop_en && t_over;
          if (steps_q == '0 || period_q == '0) begin
            res_valid_q <= 1'b1;
            shown_q     <= '0;
            step_q      <= '0;
            res_done_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end else if (cfg.loop_en) begin
            state_q <= ST_DIV1;
          end else begin
            cycle_q <= '0;
            rem_q   <= t_over ? (period_q - PER_W'(1)) : t_q[PER_W-1:0];
            state_q <= ST_MUL;
          end
        end
        ST_DIV1: begin
          if (div_rsp.done) begin
            cycle_q <= div_rsp.quotient;
            rem_q   <= div_rsp.remainder;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          base_q   <= prod[63:0];
          s_q      <= '0;
          acc_q    <= '0;
          rd_vld_q <= 1'b0;
          state_q  <= ST_SCAN;
        end
        ST_SCAN: begin
          rd_vld_q  <= issue;
          rd_step_q <= s_q;
          if (issue) begin
            s_q <= s_q + STEP_W'(1);
          end
          if (rd_vld_q) begin
            if ({1'b0, rem_q} < scan_sum) begin
              ord_q   <= base_q + 64'(rd_step_q);
              state_q <= ST_MOD;
            end else begin
              acc_q <= scan_sum[PER_W-1:0];
            end
          end else if (!issue) begin
            ord_q   <= base_q + 64'(steps_q - STEP_W'(1));
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          rd_vld_q <= 1'b0;
          state_q  <= ST_DIV2;
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            res_valid_q <= 1'b1;
            shown_q     <= out_step[FRAME_W-1:0];
            step_q      <= ord_q;
            res_done_q  <= done_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o   = res_valid_q;
  assign shown_frame_o = shown_q;
  assign step_number_o = step_q;
  assign done_res_o    = res_done_q;

  `SCFT_ASSERT(a_res_one_cycle, res_valid_o |=> !res_valid_o, "result strobe longer than one cycle")
  `SCFT_ASSERT(a_res_when_idle, res_valid_o |-> !busy, "result shown while sequencer busy")
  `SCFT_ASSERT(a_query_busy, (start && !busy && !cmd_i) |=> busy, "query request did not raise busy")
  `SCFT_ASSERT(a_div_done_state, div_rsp.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2), "divider finished outside a wait state")
  `SCFT_ASSERT(a_scan_nonempty, (state_q == ST_SCAN) |-> (steps_q != '0 && period_q != '0), "table scan on an empty clip")
  `SCFT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !res_valid_o, "result strobe during reset")

endmodule

// File: verif/sprite_clip_frame_timeline_checker.sv
// checker for the sprite clip timeline: mirrors the table and config, predicts and compares results
module sprite_clip_frame_timeline_checker
  import scft_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     cmd_i,
  input  logic [FRAME_W-1:0]       frame_slot_i,
  input  logic [DURATION_BITS-1:0] frame_duration_i,
  input  logic [63:0]              query_time_i,
  input  logic                     res_valid_o,
  input  logic [FRAME_W-1:0]       shown_frame_o,
  input  logic [63:0]              step_number_o,
  input  logic                     done_res_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  input  logic                     pready,
  output int                       fail_count_o,
  output int                       open_queries_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [63:0]        step;
    logic               done;
  } frame_pick_t;

  logic [DURATION_BITS-1:0] durations [MAX_FRAMES];
  logic [FC_W-1:0]          clip_frames;
  logic                     looping;
  logic                     bouncing;
  frame_pick_t              expected_frames [$];
  int                       fails;

  // step index to frame index, walking back through the middle frames
  function automatic int unsigned mirror_frame(int unsigned s, int unsigned n);
    return (s < n) ? s : 2 * n - 2 - s;
  endfunction

  function automatic frame_pick_t predict_frame(logic [63:0] t);
    int unsigned n;
    int unsigned steps;
    int unsigned s;
    logic [63:0] period;
    logic [63:0] acc;
    logic [63:0] cyc;
    logic [63:0] rem;
    logic [63:0] ord;
    logic [63:0] d;
    logic        found;
    frame_pick_t p;
    n = (clip_frames > MAX_FRAMES) ? MAX_FRAMES : int'(clip_frames);
    if (n == 0) begin
      steps = 0;
    end else if (n == 1 || !bouncing) begin
      steps = n;
    end else begin
      steps = 2 * n - 2;
    end
    period = '0;
    for (s = 0; s < steps; s++) period += 64'(durations[mirror_frame(s, n)]);
    if (steps == 0 || period == 0) begin
      p.frame = '0;
      p.step  = '0;
      p.done  = 1'b1;
      return p;
    end
    cyc = '0;
    rem = t;
    if (looping) begin
      cyc = t / period;
      rem = t % period;
    end else if (t >= period) begin
      rem = period - 64'd1;
    end
    ord   = cyc * 64'(steps) + 64'(steps - 1);
    acc   = '0;
    found = 1'b0;
    for (s = 0; s < steps; s++) begin
      d = 64'(durations[mirror_frame(s, n)]);
      if (!found && rem < acc + d) begin
        ord   = cyc * 64'(steps) + 64'(s);
        found = 1'b1;
      end
      acc += d;
    end
    p.frame = FRAME_W'(mirror_frame(int'(ord % 64'(steps)), n));
    p.step  = ord;
    p.done  = looping ? 1'b0 : (t >= period);
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_pick_t want;
    frame_pick_t got;
    if (!rst_ni) begin
      clip_frames = '0;
      looping     = 1'b0;
      bouncing    = 1'b0;
      foreach (durations[i]) durations[i] = '0;
      expected_frames.delete();
      fails = 0;
      fail_count_o   <= 0;
      open_queries_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_CLIP_LEN: clip_frames = pwdata[FC_W-1:0];
          REG_LOOP:     looping     = pwdata[0];
          REG_PINGPONG: bouncing    = pwdata[0];
          default: ;
        endcase
      end
      if (res_valid_o) begin
        got.frame = shown_frame_o;
        got.step  = step_number_o;
        got.done  = done_res_o;
        if (expected_frames.size() == 0) begin
          if (fails < 10) begin
            $display("result with no query waiting: frame %0d step %0d done %0b",
                     got.frame, got.step, got.done);
          end
          fails++;
        end else begin
          want = expected_frames.pop_front();
          if (got.frame !== want.frame || got.step !== want.step || got.done !== want.done) begin
            if (fails < 10) begin
              $display("mismatch: got frame %0d step %0d done %0b, expected frame %0d step %0d done %0b",
                       got.frame, got.step, got.done, want.frame, want.step, want.done);
            end
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (cmd_i) begin
          durations[frame_slot_i] = frame_duration_i;
        end else begin
          expected_frames.push_back(predict_frame(query_time_i));
        end
      end
      fail_count_o   <= fails;
      open_queries_o <= expected_frames.size();
    end
  end

endmodule

// File: verif/sprite_clip_frame_timeline_tb.sv
// testbench top for the sprite clip timeline: clock, reset, stimulus and verdict
module sprite_clip_frame_timeline_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scft_pkg::*;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam int   SETTLE_CYCLES = 400;
  localparam int   CYCLE_LIMIT   = 6_000_000;
  localparam int   RANDOM_ITEMS  = 950;

  typedef enum int {DUR_SHORT, DUR_FULL, DUR_EDGES, DUR_MOSTLY_ZERO} dur_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     cmd_i = CMD_QUERY;
  logic [FRAME_W-1:0]       frame_slot_i = '0;
  logic [DURATION_BITS-1:0] frame_duration_i = '0;
  logic [63:0]              query_time_i = '0;
  logic                     res_valid_o;
  logic [FRAME_W-1:0]       shown_frame_o;
  logic [63:0]              step_number_o;
  logic                     done_res_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  int                       fail_count;
  int                       open_queries;

  bit [MAX_FRAMES-1:0] written = '0;
  dur_mode_e           dur_mode = DUR_SHORT;
  int                  burst_left = 0;
  int                  items_sent = 0;
  int                  cycle_count = 0;

  sprite_clip_frame_timeline dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .frame_slot_i, .frame_duration_i, .query_time_i,
    .res_valid_o, .shown_frame_o, .step_number_o, .done_res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sprite_clip_frame_timeline_checker frame_check (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .frame_slot_i, .frame_duration_i, .query_time_i,
    .res_valid_o, .shown_frame_o, .step_number_o, .done_res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .open_queries_o(open_queries)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [DURATION_BITS-1:0] pick_duration();
    case (dur_mode)
      DUR_SHORT: begin
        return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      end
      DUR_FULL: return 16'($urandom);
      DUR_EDGES: begin
        case ($urandom_range(0, 3))
          0: return 16'd0;
          1: return 16'd1;
          2: return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
      default: return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 3)) : 16'd0;
    endcase
  endfunction

  task automatic send(logic kind, logic [FRAME_W-1:0] slot, logic [DURATION_BITS-1:0] dur,
                      logic [63:0] t);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 3) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 95) begin
      gap = $urandom_range(4, 12);
    end else if (r < 98) begin
      gap = $urandom_range(20, 60);
    end else begin
      gap = $urandom_range(100, 450);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    cmd_i            <= kind;
    frame_slot_i     <= slot;
    frame_duration_i <= dur;
    query_time_i     <= t;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (kind == CMD_WRITE) written[slot] = 1'b1;
  endtask

  task automatic query(logic [63:0] t);
    send(CMD_QUERY, FRAME_W'($urandom), 16'($urandom), t);
  endtask

  task automatic write_slot(logic [FRAME_W-1:0] slot, logic [DURATION_BITS-1:0] dur);
    send(CMD_WRITE, slot, dur, {$urandom, $urandom});
  endtask

  // stop requests and wait until the block is idle with nothing outstanding
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || open_queries != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // new clip settings, then fill any slot the clip reads that was never written
  task automatic reconfigure(int unsigned frames, logic loop_on, logic bounce_on);
    int unsigned n;
    int unsigned i;
    settle_idle();
    write_reg(REG_CLIP_LEN, 32'(frames));
    write_reg(REG_LOOP, 32'(loop_on));
    write_reg(REG_PINGPONG, 32'(bounce_on));
    n = (frames > MAX_FRAMES) ? MAX_FRAMES : frames;
    for (i = 0; i < n; i++) begin
      if (!written[i]) write_slot(FRAME_W'(i), pick_duration());
    end
  endtask

  initial begin
    int unsigned frames;
    int          first_random;
    int          phase_items;
    logic [63:0] t;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty clip straight out of reset
    query(64'd0);
    query('1);
    write_slot(6'd0, 16'd5);
    write_slot(6'd1, 16'd3);
    write_slot(6'd2, 16'd7);
    // single frame with ping-pong, one-shot
    reconfigure(1, 1'b0, 1'b1);
    query(64'd0);
    query(64'd4);
    query(64'd5);
    query('1);
    // ping-pong loop over three frames, period 18
    reconfigure(3, 1'b1, 1'b1);
    query(64'd0);
    query(64'd5);
    query(64'd17);
    query(64'd18);
    query('1);
    reconfigure(3, 1'b0, 1'b0);
    query(64'd14);
    query(64'd15);
    // zero period
    write_slot(6'd0, 16'd0);
    write_slot(6'd1, 16'd0);
    write_slot(6'd2, 16'd0);
    query(64'd100);
    reconfigure(3, 1'b1, 1'b0);
    query(64'd7);
    write_slot(6'd63, 16'hFFFF);

    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      dur_mode = dur_mode_e'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: frames = 0;
        1: frames = 1;
        2: frames = 2;
        3: frames = MAX_FRAMES;
        4: frames = $urandom_range(MAX_FRAMES + 1, 127);
        5: frames = $urandom_range(1, 63);
        default: frames = $urandom_range(1, 12);
      endcase
      reconfigure(frames, 1'($urandom), 1'($urandom));
      phase_items = $urandom_range(40, 90);
      repeat (phase_items) begin
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 7))
            0: t = '0;
            1, 2: t = 64'($urandom_range(0, 600));
            3: t = 64'($urandom_range(0, 1 << 20));
            4: t = {32'd0, $urandom};
            5: t = {$urandom, $urandom};
            6: t = '1 - 64'($urandom_range(0, 300));
            default: t = {$urandom, $urandom} >> $urandom_range(0, 63);
          endcase
          query(t);
        end else begin
          write_slot(FRAME_W'($urandom_range(0, MAX_FRAMES - 1)), pick_duration());
        end
      end
    end

    settle_idle();
    if (fail_count == 0 && open_queries == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
